// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies; take in with a bare include
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, switched off while reset is high
`define ALU_ASSERT_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// clocked check that also holds through reset
`define ALU_ASSERT(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/alu_pkg.sv =====
// shared types and command codes for the 8/16-bit flag alu
// no dependencies
`default_nettype none

package alu_pkg;

  // command codes
  localparam logic [4:0] CMD_ADD   = 5'd0;
  localparam logic [4:0] CMD_ADC   = 5'd1;
  localparam logic [4:0] CMD_SUB   = 5'd2;
  localparam logic [4:0] CMD_SBC   = 5'd3;
  localparam logic [4:0] CMD_AND   = 5'd4;
  localparam logic [4:0] CMD_XOR   = 5'd5;
  localparam logic [4:0] CMD_OR    = 5'd6;
  localparam logic [4:0] CMD_CP    = 5'd7;
  localparam logic [4:0] CMD_INC   = 5'd8;
  localparam logic [4:0] CMD_DEC   = 5'd9;
  localparam logic [4:0] CMD_RLC   = 5'd10;
  localparam logic [4:0] CMD_RRC   = 5'd11;
  localparam logic [4:0] CMD_RL    = 5'd12;
  localparam logic [4:0] CMD_RR    = 5'd13;
  localparam logic [4:0] CMD_SLA   = 5'd14;
  localparam logic [4:0] CMD_SRA   = 5'd15;
  localparam logic [4:0] CMD_SWAP  = 5'd16;
  localparam logic [4:0] CMD_SRL   = 5'd17;
  localparam logic [4:0] CMD_BIT   = 5'd18;
  localparam logic [4:0] CMD_RES   = 5'd19;
  localparam logic [4:0] CMD_SET   = 5'd20;
  localparam logic [4:0] CMD_ADD16 = 5'd21;
  localparam logic [4:0] CMD_ADDSP = 5'd22;
  localparam logic [4:0] CMD_INC16 = 5'd23;
  localparam logic [4:0] CMD_DEC16 = 5'd24;

  // one command transfer
  typedef struct packed {
    logic [4:0]  command;
    logic [15:0] operand_a;
    logic [15:0] operand_b;
    logic [2:0]  bit_index;
    logic        zero_in;
    logic        subtract_in;
    logic        half_carry_in;
    logic        carry_in;
  } alu_in_t;

  // one result transfer
  typedef struct packed {
    logic [15:0] result;
    logic        zero_out;
    logic        subtract_out;
    logic        half_carry_out;
    logic        carry_out;
  } alu_out_t;

endpackage

`default_nettype wire

// ===== rtl/alu_core.sv =====
// combinational datapath: result word and new flags for one command
// depends on alu_pkg
`default_nettype none

module alu_core (
  input  alu_pkg::alu_in_t  req,
  output alu_pkg::alu_out_t resp
);
  import alu_pkg::*;

  logic [7:0]  a;
  logic [7:0]  b;
  logic        ci;
  logic [8:0]  sum9;
  logic [4:0]  nib5;
  logic [8:0]  diff9;
  logic [4:0]  nibd5;
  logic [7:0]  res8;
  logic [7:0]  mask8;
  logic [16:0] sum17;
  logic [12:0] sum13;
  logic [15:0] res16;
  logic        is8;
  logic        z;
  logic        n;
  logic        h;
  logic        c;

  assign a     = req.operand_a[7:0];
  assign b     = req.operand_b[7:0];
  assign mask8 = 8'd1 << req.bit_index;

  // carry in for the with-carry forms only
  assign ci = ((req.command == CMD_ADC) || (req.command == CMD_SBC)) ? req.carry_in : 1'b0;

  // shared 8-bit adder and subtractor with nibble carries
  assign sum9  = {1'b0, a} + {1'b0, b} + {8'd0, ci};
  assign nib5  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, ci};
  assign diff9 = {1'b0, a} - {1'b0, b} - {8'd0, ci};
  assign nibd5 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, ci};

  // 16-bit add with carries out of bit 11 and bit 15
  assign sum17 = {1'b0, req.operand_a} + {1'b0, req.operand_b};
  assign sum13 = {1'b0, req.operand_a[11:0]} + {1'b0, req.operand_b[11:0]};

  // operation select
  always_comb begin
    res8  = 8'd0;
    res16 = 16'd0;
    is8   = 1'b0;
    z     = req.zero_in;
    n     = req.subtract_in;
    h     = req.half_carry_in;
    c     = req.carry_in;
    unique case (req.command)
      CMD_ADD, CMD_ADC: begin
        is8 = 1'b1; res8 = sum9[7:0];
        n = 1'b0; h = nib5[4]; c = sum9[8];
      end
      CMD_SUB, CMD_SBC, CMD_CP: begin
        is8 = 1'b1; res8 = diff9[7:0];
        n = 1'b1; h = nibd5[4]; c = diff9[8];
      end
      CMD_AND: begin
        is8 = 1'b1; res8 = a & b; n = 1'b0; h = 1'b1; c = 1'b0;
      end
      CMD_XOR: begin
        is8 = 1'b1; res8 = a ^ b; n = 1'b0; h = 1'b0; c = 1'b0;
      end
      CMD_OR: begin
        is8 = 1'b1; res8 = a | b; n = 1'b0; h = 1'b0; c = 1'b0;
      end
      CMD_INC: begin
        is8 = 1'b1; res8 = a + 8'd1; n = 1'b0; h = (a[3:0] == 4'hF);
      end
      CMD_DEC: begin
        is8 = 1'b1; res8 = a - 8'd1; n = 1'b1; h = (a[3:0] == 4'h0);
      end
      CMD_RLC: begin
        is8 = 1'b1; res8 = {a[6:0], a[7]}; n = 1'b0; h = 1'b0; c = a[7];
      end
      CMD_RRC: begin
        is8 = 1'b1; res8 = {a[0], a[7:1]}; n = 1'b0; h = 1'b0; c = a[0];
      end
      CMD_RL: begin
        is8 = 1'b1; res8 = {a[6:0], req.carry_in}; n = 1'b0; h = 1'b0; c = a[7];
      end
      CMD_RR: begin
        is8 = 1'b1; res8 = {req.carry_in, a[7:1]}; n = 1'b0; h = 1'b0; c = a[0];
      end
      CMD_SLA: begin
        is8 = 1'b1; res8 = {a[6:0], 1'b0}; n = 1'b0; h = 1'b0; c = a[7];
      end
      CMD_SRA: begin
        is8 = 1'b1; res8 = {a[7], a[7:1]}; n = 1'b0; h = 1'b0; c = a[0];
      end
      CMD_SWAP: begin
        is8 = 1'b1; res8 = {a[3:0], a[7:4]}; n = 1'b0; h = 1'b0; c = 1'b0;
      end
      CMD_SRL: begin
        is8 = 1'b1; res8 = {1'b0, a[7:1]}; n = 1'b0; h = 1'b0; c = a[0];
      end
      CMD_BIT: begin
        res16 = {8'd0, a};
        z = ((a & mask8) == 8'd0); n = 1'b0; h = 1'b1;
      end
      CMD_RES:   res16 = {8'd0, a & ~mask8};
      CMD_SET:   res16 = {8'd0, a | mask8};
      CMD_ADD16: begin
        res16 = sum17[15:0]; n = 1'b0; h = sum13[12]; c = sum17[16];
      end
      CMD_ADDSP: begin
        res16 = req.operand_a + {{8{b[7]}}, b};
        z = 1'b0; n = 1'b0;
        h = ({1'b0, req.operand_a[3:0]} + {1'b0, b[3:0]}) >> 4 != 5'd0;
        c = ({1'b0, req.operand_a[7:0]} + {1'b0, b}) >> 8 != 9'd0;
      end
      CMD_INC16: res16 = req.operand_a + 16'd1;
      CMD_DEC16: res16 = req.operand_a - 16'd1;
      default:   res16 = 16'd0;
    endcase
    // 8-bit forms set zero from the byte; compare keeps the accumulator
    if (is8) begin
      z     = (res8 == 8'd0);
      res16 = (req.command == CMD_CP) ? {8'd0, a} : {8'd0, res8};
    end
  end

  assign resp.result         = res16;
  assign resp.zero_out       = z;
  assign resp.subtract_out   = n;
  assign resp.half_carry_out = h;
  assign resp.carry_out      = c;

endmodule

`default_nettype wire

// ===== rtl/cpu_alu_with_flags.sv =====
// top level of the 8/16-bit alu with zero, subtract, half-carry and carry flags
// depends on alu_pkg and alu_core
//
// usage
//   a command transfer is taken at a rising edge with start high and busy low;
//   request carries the command, both operands, the bit index and the four
//   incoming flags
//   busy is low at all times outside reset, so a new command can be issued on
//   every cycle
//   the result appears on response with done high for exactly one cycle
//   path: the command is registered in the input register when taken, then the
//   result and done are registered in the result register
//   throughput: one command per cycle, set by the single register-to-register
//   pass through the alu datapath
//   reset: synchronous and active high; busy is high while rst is high, the
//   pipeline valid bits are cleared and no done strobe follows a command taken
//   before reset
//   the receiver cannot stall: each result is taken in its done cycle
`default_nettype none

module cpu_alu_with_flags (
  input  wire                clk,
  input  wire                rst,
  input  wire                start,
  output logic               busy,
  input  alu_pkg::alu_in_t   request,
  output logic               done,
  output alu_pkg::alu_out_t  response
);
  import alu_pkg::*;

  logic     stage_valid;
  alu_in_t  stage_req;
  alu_out_t response_next;

  // only reset holds off a transfer
  assign busy = rst;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else begin
      stage_valid <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      stage_req <= request;
    end
  end

  // datapath
  alu_core u_core (
    .req  (stage_req),
    .resp (response_next)
  );

  // result register and strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_valid) begin
      response <= response_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/alu_checker.sv =====
// port-level checks on the alu: strobe timing and a few result rules
// depends on alu_pkg and assert_macros.svh; bound to cpu_alu_with_flags
`default_nettype none
`include "assert_macros.svh"

module alu_checker (
  input wire               clk,
  input wire               rst,
  input wire               start,
  input wire               busy,
  input alu_pkg::alu_in_t  request,
  input wire               done,
  input alu_pkg::alu_out_t response
);
  import alu_pkg::*;

  logic accept;

  assign accept = start && !busy;

  // 16-bit increment wraps and leaves the carry and zero flags alone
  property p_inc16;
    (done && $past(accept && (request.command == CMD_INC16), 2)) |->
      ((response.result == 16'($past(request.operand_a, 2) + 16'd1)) &&
       (response.carry_out == $past(request.carry_in, 2)) &&
       (response.zero_out == $past(request.zero_in, 2)));
  endproperty

  // byte commands leave the upper result byte clear
  property p_upper_zero;
    (done && $past(accept && (request.command <= CMD_SET), 2)) |->
      (response.result[15:8] == 8'd0);
  endproperty

  // every taken command is followed by one done strobe
  `ALU_ASSERT_RST(a_done_follows, clk, rst, accept |=> ##1 done, "missing done strobe")

  // no strobe without a command taken before it
  `ALU_ASSERT_RST(a_done_cause, clk, rst, done |-> $past(accept, 2), "spurious done strobe")

  // busy only during reset, so no transfer is lost outside reset
  `ALU_ASSERT(a_busy_reset, clk, busy == rst, "busy outside reset")

  `ALU_ASSERT_RST(a_inc16, clk, rst, p_inc16, "inc16 result or flags wrong")

  `ALU_ASSERT_RST(a_upper_zero, clk, rst, p_upper_zero, "upper byte set on byte command")

endmodule

bind cpu_alu_with_flags alu_checker u_alu_checker (.*);

`default_nettype wire
